### hw/rtl/epcm_pkg.sv
// Shared constants, types and helpers for the pose-to-camera-matrix block.
`timescale 1ns / 1ps
`default_nettype none
package epcm_pkg;

  localparam int NSTEP = 6;
  // sincos pipeline: phase, square, three stages per Horner step, final two
  localparam int SC_LAT = 2 + 3 * NSTEP + 2;

  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [7:0] SIN_DIV [NSTEP] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [NSTEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // floor(2^32 / k)
  localparam logic [31:0] SIN_REC [NSTEP] = '{
    32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
    32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_REC [NSTEP] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

  localparam logic [7:0]  POS_DIV = 8'd100;
  localparam logic [31:0] POS_REC = 32'((64'd1 << 32) / 64'd100);
  localparam logic [31:0] POS_HALF = 32'd50;

  localparam logic [1:0] LAST_ROW = 2'd2;

  // values carried alongside the Horner steps
  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [1:0]  quad;
  } sc_carry_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        view;
  } pose_side_t;

  // floor(n / k) from m = n * floor(2^32 / k); estimate is low by at most one
  function automatic logic [31:0] div_fix(input logic [31:0] n, input logic [62:0] m,
                                          input logic [7:0] k);
    logic [30:0] qe;
    logic [39:0] rem;
    qe  = m[62:32];
    rem = {8'd0, n} - 40'(qe) * 40'(k);
    return (rem >= 40'(k)) ? 32'(qe) + 32'd1 : 32'(qe);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/epcm_sincos.sv
// Pipelined fixed-point sine/cosine of a binary angle (Taylor series, Horner steps).
`timescale 1ns / 1ps
`default_nettype none
module epcm_sincos #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_FRAC_BITS = 14,
  localparam int CW = COEF_FRAC_BITS + 2
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [ANGLE_BITS-1:0]  angle,
  output logic signed [CW-1:0]        sin_o,
  output logic signed [CW-1:0]        cos_o
);
  localparam int NS = epcm_pkg::NSTEP;
  localparam int NC = 3 * NS;

  logic [29:0] ph_lo;
  assign ph_lo = {angle[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};

  logic [1:0]  quad0_r;
  logic [60:0] xp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      quad0_r <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
      xp_r    <= 61'(ph_lo) * 61'(epcm_pkg::HALF_PI_Q30);
    end
  end

  logic [30:0] x1_nxt;
  logic [30:0] x1_r;
  logic [61:0] x2p_r;
  logic [1:0]  quad1_r;
  assign x1_nxt = xp_r[60:30];
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      x2p_r   <= 62'(x1_nxt) * 62'(x1_nxt);
      quad1_r <= quad0_r;
    end
  end

  epcm_pkg::sc_carry_t cr_in;
  epcm_pkg::sc_carry_t cr_r [NC];
  assign cr_in = '{x: x1_r, x2: x2p_r[61:30], quad: quad1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= cr_in;
      for (int i = 1; i < NC; i++) cr_r[i] <= cr_r[i-1];
    end
  end

  logic [31:0] x2a   [NS];
  logic [30:0] tsa   [NS];
  logic [30:0] tca   [NS];
  logic [62:0] pa_s_r [NS];
  logic [62:0] pa_c_r [NS];
  logic [31:0] n_s_r  [NS];
  logic [31:0] n_c_r  [NS];
  logic [62:0] m_s_r  [NS];
  logic [62:0] m_c_r  [NS];
  logic [30:0] ts_r   [NS];
  logic [30:0] tc_r   [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [31:0] n_s_nxt, n_c_nxt, q_s, q_c;
    if (j == 0) begin : g_first
      assign x2a[j] = cr_in.x2;
      assign tsa[j] = epcm_pkg::ONE_Q30;
      assign tca[j] = epcm_pkg::ONE_Q30;
    end else begin : g_next
      assign x2a[j] = cr_r[3*j-1].x2;
      assign tsa[j] = ts_r[j-1];
      assign tca[j] = tc_r[j-1];
    end
    assign n_s_nxt = pa_s_r[j][61:30];
    assign n_c_nxt = pa_c_r[j][61:30];
    assign q_s = epcm_pkg::div_fix(n_s_r[j], m_s_r[j], epcm_pkg::SIN_DIV[j]);
    assign q_c = epcm_pkg::div_fix(n_c_r[j], m_c_r[j], epcm_pkg::COS_DIV[j]);
    always_ff @(posedge clk) begin
      if (en) begin
        pa_s_r[j] <= 63'(x2a[j]) * 63'(tsa[j]);
        pa_c_r[j] <= 63'(x2a[j]) * 63'(tca[j]);
        n_s_r[j]  <= n_s_nxt;
        n_c_r[j]  <= n_c_nxt;
        m_s_r[j]  <= 63'(n_s_nxt) * 63'(epcm_pkg::SIN_REC[j]);
        m_c_r[j]  <= 63'(n_c_nxt) * 63'(epcm_pkg::COS_REC[j]);
        ts_r[j]   <= 31'(32'(epcm_pkg::ONE_Q30) - q_s);
        tc_r[j]   <= 31'(32'(epcm_pkg::ONE_Q30) - q_c);
      end
    end
  end

  // final sine multiply by x
  logic [61:0] sp_r;
  logic [30:0] tcf_r;
  logic [1:0]  qf_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r  <= 62'(cr_r[NC-1].x) * 62'(ts_r[NS-1]);
      tcf_r <= tc_r[NS-1];
      qf_r  <= cr_r[NC-1].quad;
    end
  end

  logic signed [32:0] s33, c33;
  logic signed [CW-1:0] sc, cc, sin_nxt, cos_nxt;
  assign s33 = $signed({1'b0, sp_r[61:30]});
  assign c33 = $signed({2'b00, tcf_r});

  if (COEF_FRAC_BITS < 30) begin : g_round
    localparam int SH = 30 - COEF_FRAC_BITS;
    localparam logic signed [32:0] HALF = 33'sd1 <<< (SH - 1);
    logic signed [32:0] sr, cr;
    assign sr = (s33 + HALF) >>> SH;
    assign cr = (c33 + HALF) >>> SH;
    assign sc = CW'(sr);
    assign cc = CW'(cr);
  end else begin : g_noround
    assign sc = CW'(s33);
    assign cc = CW'(c33);
  end

  always_comb begin
    case (qf_r)
      2'd0: begin sin_nxt = sc;  cos_nxt = cc;  end
      2'd1: begin sin_nxt = cc;  cos_nxt = -sc; end
      2'd2: begin sin_nxt = -sc; cos_nxt = -cc; end
      default: begin sin_nxt = -cc; cos_nxt = sc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= sin_nxt;
      cos_o <= cos_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/euler_pose_to_camera_matrix.sv
// Top level: camera pose in, three camera-to-world matrix rows out.
// Usage:
//   Input channel (in_valid/in_ready) takes one pose per request: position
//   x, y, z in 1/16 cm, pitch and yaw as binary angles, and field of view.
//   Result channel (out_valid/out_ready) returns three requests per pose,
//   rows 0, 1, 2 in order; out_last_row marks row 2.
//   Each row: rotation terms col_a/b/c (Q1.COEF_FRAC_BITS, masked to 16
//   bits), shift_term = position component / 100 rounded, view copied.
// Path: a pose passes the sine/cosine pipeline, then P1 (products, /100
//   multiply) and P2 (rounding, /100 correction), then loads the row
//   sequencer; rows 1 and 2 follow in order as each row is accepted.
// Flow: the row sequencer owns the single result channel; it loads a new
//   pose when empty or when row 2 is accepted. The pipeline takes a pose
//   every cycle unless P2 holds one that the sequencer cannot load yet.
// Stall: when out_ready is low the sequencer holds its row; the pipeline
//   freezes as soon as its last stage holds a pose, and in_ready drops.
//   Nothing is dropped or repeated.
// Reset: rst_n low (synchronous) empties the pipeline and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module euler_pose_to_camera_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [31:0]    in_pos_x,
  input  wire logic signed [31:0]    in_pos_y,
  input  wire logic signed [31:0]    in_pos_z,
  input  wire logic [ANGLE_BITS-1:0] in_pitch_angle,
  input  wire logic [ANGLE_BITS-1:0] in_yaw_angle,
  input  wire logic [15:0]           in_view_width,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_row_index,
  output logic signed [15:0]         out_col_a,
  output logic signed [15:0]         out_col_b,
  output logic signed [15:0]         out_col_c,
  output logic signed [25:0]         out_shift_term,
  output logic [15:0]                out_view_out,
  output logic                       out_last_row
);
  localparam int CW  = COEF_FRAC_BITS + 2;
  localparam int PW  = 2 * CW;
  localparam int LAT = epcm_pkg::SC_LAT;

  // sign-extend or mask a coefficient to the 16-bit field
  function automatic logic [15:0] trim16(input logic signed [CW:0] v);
    logic signed [CW+16:0] e;
    e = (CW + 17)'(v);
    return e[15:0];
  endfunction

  logic adv;       // whole pipeline advances
  logic ser_take;  // row sequencer loads a new pose

  // ---------------- sine / cosine pipelines ----------------
  logic signed [CW-1:0] sp, cp, sy, cy;

  epcm_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pitch (
    .clk(clk), .en(adv), .angle(in_pitch_angle), .sin_o(sp), .cos_o(cp));
  epcm_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_yaw (
    .clk(clk), .en(adv), .angle(in_yaw_angle), .sin_o(sy), .cos_o(cy));

  // valid bits and position/view ride alongside
  logic               v_r    [LAT];
  epcm_pkg::pose_side_t side_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{px: in_pos_x, py: in_pos_y, pz: in_pos_z, view: in_view_width};
      for (int i = 1; i < LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---------------- P1: products, |pos| + 50 times 1/100 ----------------
  epcm_pkg::pose_side_t sd;
  assign sd = side_r[LAT-1];

  logic signed [32:0] pos_v [3];
  assign pos_v[0] = 33'(sd.py);
  assign pos_v[1] = -33'(sd.pz);
  assign pos_v[2] = 33'(sd.px);

  logic               p1_v_r;
  logic signed [PW-1:0] pr_r [4];   // sy*sp, sy*cp, cy*sp, cy*cp
  logic [15:0]        a0_r, b1_r, c1_r, a2_r, view1_r;
  logic [31:0]        pn_r  [3];
  logic [62:0]        pm_r  [3];
  logic               pneg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p1_v_r <= 1'b0;
    else if (adv) p1_v_r <= v_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    logic [32:0] mag;
    logic [31:0] n;
    if (adv) begin
      pr_r[0] <= PW'(sy) * PW'(sp);
      pr_r[1] <= PW'(sy) * PW'(cp);
      pr_r[2] <= PW'(cy) * PW'(sp);
      pr_r[3] <= PW'(cy) * PW'(cp);
      a0_r    <= trim16((CW + 1)'(cy));
      b1_r    <= trim16(-(CW + 1)'(cp));
      c1_r    <= trim16((CW + 1)'(sp));
      a2_r    <= trim16(-(CW + 1)'(sy));
      view1_r <= sd.view;
      for (int i = 0; i < 3; i++) begin
        mag = pos_v[i][32] ? 33'(-pos_v[i]) : 33'(pos_v[i]);
        n = 32'(mag) + epcm_pkg::POS_HALF;
        pneg_r[i] <= pos_v[i][32];
        pn_r[i]   <= n;
        pm_r[i]   <= 63'(n) * 63'(epcm_pkg::POS_REC);
      end
    end
  end

  // ---------------- P2: rounding, negation, /100 correction ----------------
  localparam logic [PW-1:0] CHALF = PW'(1) << (COEF_FRAC_BITS - 1);

  logic        p2_v_r;
  logic [15:0] bc_r [4];   // -round(prod), row 0 b, c, row 2 b, c
  logic [15:0] a0_2_r, b1_2_r, c1_2_r, a2_2_r, view2_r;
  logic [25:0] sh_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) p2_v_r <= 1'b0;
    else if (adv) p2_v_r <= p1_v_r;
  end

  always_ff @(posedge clk) begin
    logic [PW-1:0] pm;
    logic [31:0]   q;
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pm = pr_r[i][PW-1] ? PW'(-pr_r[i]) : PW'(pr_r[i]);
        pm = (pm + CHALF) >> COEF_FRAC_BITS;
        bc_r[i] <= pr_r[i][PW-1] ? pm[15:0] : 16'(-pm);
      end
      for (int i = 0; i < 3; i++) begin
        q = epcm_pkg::div_fix(pn_r[i], pm_r[i], epcm_pkg::POS_DIV);
        sh_r[i] <= pneg_r[i] ? 26'(-q) : 26'(q);
      end
      a0_2_r  <= a0_r;
      b1_2_r  <= b1_r;
      c1_2_r  <= c1_r;
      a2_2_r  <= a2_r;
      view2_r <= view1_r;
    end
  end

  // ---------------- row sequencer ----------------
  logic        ser_v_r;
  logic [1:0]  row_r;
  logic [15:0] ra_r [3];
  logic [15:0] rb_r [3];
  logic [15:0] rc_r [3];
  logic [25:0] rt_r [3];
  logic [15:0] rview_r;

  assign ser_take = !ser_v_r || (out_ready && (row_r == epcm_pkg::LAST_ROW));
  assign adv      = !p2_v_r || ser_take;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      row_r   <= 2'd0;
    end else if (ser_take) begin
      ser_v_r <= p2_v_r;
      row_r   <= 2'd0;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ra_r[0] <= a0_2_r;  rb_r[0] <= bc_r[0]; rc_r[0] <= bc_r[1];
      ra_r[1] <= 16'd0;   rb_r[1] <= b1_2_r;  rc_r[1] <= c1_2_r;
      ra_r[2] <= a2_2_r;  rb_r[2] <= bc_r[2]; rc_r[2] <= bc_r[3];
      for (int i = 0; i < 3; i++) rt_r[i] <= sh_r[i];
      rview_r <= view2_r;
    end
  end

  logic [1:0] rsel;
  assign rsel = (row_r > epcm_pkg::LAST_ROW) ? epcm_pkg::LAST_ROW : row_r;

  assign out_valid      = ser_v_r;
  assign out_row_index  = row_r;
  assign out_col_a      = ra_r[rsel];
  assign out_col_b      = rb_r[rsel];
  assign out_col_c      = rc_r[rsel];
  assign out_shift_term = rt_r[rsel];
  assign out_view_out   = rview_r;
  assign out_last_row   = (row_r == epcm_pkg::LAST_ROW);

endmodule
`default_nettype wire

### sim/euler_pose_to_camera_matrix_test.sv
// Testbench for euler_pose_to_camera_matrix: random and directed poses, row-by-row checking.
`timescale 1ns / 1ps
module euler_pose_to_camera_matrix_test;

  localparam int FRAC  = 14;
  localparam longint Q30_ONE  = 64'd1073741824;
  localparam longint Q30_HPI  = 64'd1686629713;
  localparam int WATCHDOG = 5000;

  // one pose request
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        pitch;
    logic [15:0]        yaw;
    logic [15:0]        view;
  } pose_t;

  // one matrix row result
  typedef struct packed {
    logic [1:0]         row;
    logic signed [15:0] ca;
    logic signed [15:0] cb;
    logic signed [15:0] cc;
    logic signed [25:0] shift;
    logic [15:0]        view;
    logic               last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_pitch_angle = '0, in_yaw_angle = '0, in_view_width = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_row_index;
  logic signed [15:0] out_col_a, out_col_b, out_col_c;
  logic signed [25:0] out_shift_term;
  logic [15:0] out_view_out;
  logic out_last_row;

  euler_pose_to_camera_matrix DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_pitch_angle(in_pitch_angle), .in_yaw_angle(in_yaw_angle),
    .in_view_width(in_view_width),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_col_a(out_col_a), .out_col_b(out_col_b),
    .out_col_c(out_col_c), .out_shift_term(out_shift_term),
    .out_view_out(out_view_out), .out_last_row(out_last_row)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  pose_t pending_poses[$];
  row_t  expected_rows[$];
  int    errors = 0;
  bit    no_idle = 0;      // long stretch with both sides always busy
  bit    hold_rx = 0;      // receiver hold-off request
  int    idle_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint sin_taylor(longint x);
    longint x2, t;
    x2 = qmul(x, x);
    t = Q30_ONE - qmul(x2, Q30_ONE) / 156;
    t = Q30_ONE - qmul(x2, t) / 110;
    t = Q30_ONE - qmul(x2, t) / 72;
    t = Q30_ONE - qmul(x2, t) / 42;
    t = Q30_ONE - qmul(x2, t) / 20;
    t = Q30_ONE - qmul(x2, t) / 6;
    return qmul(x, t);
  endfunction

  function automatic longint cos_taylor(longint x);
    longint x2, t;
    x2 = qmul(x, x);
    t = Q30_ONE - qmul(x2, Q30_ONE) / 132;
    t = Q30_ONE - qmul(x2, t) / 90;
    t = Q30_ONE - qmul(x2, t) / 56;
    t = Q30_ONE - qmul(x2, t) / 30;
    t = Q30_ONE - qmul(x2, t) / 12;
    return Q30_ONE - qmul(x2, t) / 2;
  endfunction

  // Q30 to coefficient, round half up
  function automatic longint q30_to_coef(longint v);
    return (v + (64'd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
  endfunction

  task automatic angle_sincos(input logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] ph;
    longint x, s, c;
    ph = {ang, 16'd0};
    x = (longint'(ph[29:0]) * Q30_HPI) >>> 30;
    s = q30_to_coef(sin_taylor(x));
    c = q30_to_coef(cos_taylor(x));
    case (ph[31:30])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  // product rounded to nearest, halves away from zero
  function automatic longint coef_product(longint a, longint b);
    longint p, m;
    p = a * b;
    m = p < 0 ? -p : p;
    m = (m + (64'd1 <<< (FRAC - 1))) >>> FRAC;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint pos_to_shift(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + 50) / 100;
    return v < 0 ? -m : m;
  endfunction

  function automatic row_t make_row(logic [1:0] r, longint a, longint b, longint c,
                                    longint t, logic [15:0] v);
    row_t o;
    o.row = r; o.ca = a[15:0]; o.cb = b[15:0]; o.cc = c[15:0];
    o.shift = t[25:0]; o.view = v; o.last = (r == 2'd2);
    return o;
  endfunction

  task automatic predict_rows(input pose_t p);
    longint sp, cp, sy, cy;
    angle_sincos(p.pitch, sp, cp);
    angle_sincos(p.yaw, sy, cy);
    expected_rows.push_back(make_row(2'd0, cy, -coef_product(sy, sp), -coef_product(sy, cp),
                                     pos_to_shift(longint'(p.py)), p.view));
    expected_rows.push_back(make_row(2'd1, 0, -cp, sp, pos_to_shift(-longint'(p.pz)), p.view));
    expected_rows.push_back(make_row(2'd2, -sy, -coef_product(cy, sp), -coef_product(cy, cp),
                                     pos_to_shift(longint'(p.px)), p.view));
  endtask

  // ---------------- driver ----------------
  pose_t cur;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_rows(cur);
      end
      if (!in_valid || in_ready) begin
        // slot free: offer next request or idle
        if (pending_poses.size() > 0 && (no_idle || hold_rx || $urandom_range(99) >= 17)) begin
          cur = pending_poses.pop_front();
          in_valid <= 1'b1;
          in_pos_x <= cur.px; in_pos_y <= cur.py; in_pos_z <= cur.pz;
          in_pitch_angle <= cur.pitch; in_yaw_angle <= cur.yaw;
          in_view_width <= cur.view;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver / monitor ----------------
  row_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_row_index, out_col_a, out_col_b, out_col_c, out_shift_term,
                out_view_out, out_last_row};
        if (expected_rows.size() == 0) begin
          $error("unexpected row request: row %0d", got.row);
          errors++;
        end else begin
          want = expected_rows.pop_front();
          if (got.row !== want.row) begin
            $error("row_index exp %0d got %0d", want.row, got.row); errors++;
          end
          if (got.ca !== want.ca) begin
            $error("col_a exp %0d got %0d", want.ca, got.ca); errors++;
          end
          if (got.cb !== want.cb) begin
            $error("col_b exp %0d got %0d", want.cb, got.cb); errors++;
          end
          if (got.cc !== want.cc) begin
            $error("col_c exp %0d got %0d", want.cc, got.cc); errors++;
          end
          if (got.shift !== want.shift) begin
            $error("shift_term exp %0d got %0d", want.shift, got.shift); errors++;
          end
          if (got.view !== want.view) begin
            $error("view_out exp %0d got %0d", want.view, got.view); errors++;
          end
          if (got.last !== want.last) begin
            $error("last_row exp %0d got %0d", want.last, got.last); errors++;
          end
        end
      end
      out_ready <= !hold_rx && (no_idle || $urandom_range(99) >= 17);
      // watchdog: cycles with nothing accepted
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else if (!hold_rx) idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic pose_t rand_pose();
    pose_t p;
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    p.pitch = $urandom; p.yaw = $urandom; p.view = $urandom;
    // small positions often, to hit rounding ties
    if ($urandom_range(3) == 0) begin
      p.px = $signed($urandom_range(400)) - 200;
      p.py = 32'(50 * ($signed($urandom_range(8)) - 4));
      p.pz = $signed($urandom_range(400)) - 200;
    end
    return p;
  endfunction

  function automatic pose_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [15:0] pi, logic [15:0] ya, logic [15:0] v);
    pose_t p;
    p = '{x, y, z, pi, ya, v};
    return p;
  endfunction

  int k;
  initial begin
    // directed: field extremes, quadrant edges, -pi, halves in /100
    pending_poses.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_poses.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF,
                               16'hFFFF));
    pending_poses.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
                               0));
    pending_poses.push_back(mk(50, -50, 150, 16'h4000, 16'hC000, 16'h1234));
    pending_poses.push_back(mk(-150, 49, -49, 16'hC000, 16'h4000, 16'h8000));
    pending_poses.push_back(mk(-1, 1, 99, 16'h2000, 16'hE000, 16'h3243));
    pending_poses.push_back(mk(250, -250, 32'h80000001, 16'h0001, 16'hFFFF, 16'h0001));
    pending_poses.push_back(mk(100, -100, 51, 16'h3FFF, 16'h4001, 16'h7FFF));
    pending_poses.push_back(mk(-51, 32'h7FFFFFCE, 32'h80000032, 16'hBFFF, 16'h8001, 16'h5555));
    pending_poses.push_back(mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA, 16'h5555,
                               16'hAAAA));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < 280; k++) pending_poses.push_back(rand_pose());
    // no-idle stretch in the middle
    wait (pending_poses.size() < 200);
    @(posedge clk); no_idle <= 1'b1;
    wait (pending_poses.size() < 140);
    @(posedge clk); no_idle <= 1'b0;
    // receiver hold-off while the sender keeps offering: pipeline fills, input stalls
    wait (pending_poses.size() < 100);
    @(posedge clk); hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
    wait (pending_poses.size() == 0 && !in_valid);
    wait (expected_rows.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
